/* rtl/zfpa_pkg.sv */
// Shared constants and types for the zoned free page allocator.
package zfpa_pkg;

    localparam int ZONE_DEPTH_DEF = 1024;
    localparam int PAGE_BITS_DEF  = 40;
    localparam int PAGE_SHIFT     = 12;
    localparam int LIMIT_W        = 52;
    localparam int MAXA_W         = 64;
    localparam int TOTAL_W        = 12;
    localparam int STATUS_W       = 2;
    localparam int ZONE_W         = 2;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 64;

    typedef logic [ZONE_W-1:0]    t_zone;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_zone ZONE_DMA    = 2'd0;
    localparam t_zone ZONE_DMA32  = 2'd1;
    localparam t_zone ZONE_NORMAL = 2'd2;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_NONE = 2'd1;
    localparam t_status ST_FULL = 2'd2;
    localparam t_status ST_NULL = 2'd3;

    localparam logic OP_FREE  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam t_cfg_idx CFG_DMA_LIMIT   = 1'd0;
    localparam t_cfg_idx CFG_DMA32_LIMIT = 1'd1;

    localparam logic [LIMIT_W-1:0] DMA_LIMIT_RST   = 52'h0_0000_0100_0000;
    localparam logic [LIMIT_W-1:0] DMA32_LIMIT_RST = 52'h0_0001_0000_0000;

endpackage

/* rtl/zoned_free_page_allocator_top.sv */
// Zoned free page allocator: three LIFO page stacks in one shared synchronous RAM.
// Each result strobes in the cycle after its request is accepted.
// Throughput: 1 request per cycle while busy is low; one RAM access (push write or pop read) per request.
// Reset (sync, active low): stacks empty, free total 0, zone limits to defaults; no RAM
// clearing pass. Busy is high through reset and the first cycle after it.
// cfg_ready is low then too, and while start is high, so limits never move under a request.
module zoned_free_page_allocator_top #(
    parameter int ZONE_DEPTH = zfpa_pkg::ZONE_DEPTH_DEF,
    parameter int PAGE_BITS  = zfpa_pkg::PAGE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_opcode,
    input  logic [PAGE_BITS-1:0]              i_page_number,
    input  logic [zfpa_pkg::MAXA_W-1:0]       i_max_address,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [zfpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [zfpa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // result channel
    output logic                              o_strobe,
    output logic [zfpa_pkg::STATUS_W-1:0]     o_status,
    output logic [PAGE_BITS-1:0]              o_granted_page,
    output logic [zfpa_pkg::TOTAL_W-1:0]      o_free_total
);
    import zfpa_pkg::*;

    // Stack pointer width holds 0..ZONE_DEPTH; RAM row index is {zone, slot}.
    localparam int AW        = $clog2(ZONE_DEPTH);
    localparam int TW        = $clog2(ZONE_DEPTH + 1);
    localparam int MEM_DEPTH = 3 << AW;
    localparam int MW        = $clog2(MEM_DEPTH);
    localparam logic [TW-1:0] FULL_CNT = TW'(ZONE_DEPTH);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic                 r_run;
    logic [LIMIT_W-1:0]   r_dma_limit;
    logic [LIMIT_W-1:0]   r_dma32_limit;
    logic [TW-1:0]        r_top_dma;
    logic [TW-1:0]        r_top_dma32;
    logic [TW-1:0]        r_top_norm;
    logic [TOTAL_W-1:0]   r_total;
    logic                 r_strobe;
    t_status              r_status;
    logic                 r_grant;
    logic [PAGE_BITS-1:0] r_rd_data;

    // All three zone stacks share one RAM; each request does at most one access.
    logic [PAGE_BITS-1:0] mem [MEM_DEPTH];

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic                 w_accept;
    logic [MAXA_W-1:0]    w_free_addr;
    logic [MAXA_W-1:0]    w_dma_lim;
    logic [MAXA_W-1:0]    w_dma32_lim;
    logic                 w_page_null;
    t_zone                w_free_zone;
    t_zone                w_alloc_zone;
    logic                 w_found;
    t_zone                w_zone;
    logic [TW-1:0]        w_top;
    logic [TW-1:0]        w_top_dec;
    logic                 w_full;
    logic                 w_push;
    logic                 w_pop;
    logic [MW-1:0]        w_wr_addr;
    logic [MW-1:0]        w_rd_addr;
    logic [TW-1:0]        n_top;
    logic [TOTAL_W-1:0]   n_total;
    t_status              n_status;
    logic                 w_dma_ne;
    logic                 w_dma32_ne;
    logic                 w_norm_ne;

    assign w_accept    = start && r_run;
    assign w_free_addr = MAXA_W'({i_page_number, {PAGE_SHIFT{1'b0}}});
    assign w_dma_lim   = MAXA_W'(r_dma_limit);
    assign w_dma32_lim = MAXA_W'(r_dma32_limit);
    assign w_page_null = (i_page_number == '0);

    assign w_dma_ne    = (r_top_dma != '0);
    assign w_dma32_ne  = (r_top_dma32 != '0);
    assign w_norm_ne   = (r_top_norm != '0);

    // Freed page: DMA test first, then DMA32, else normal.
    always_comb begin
        if (w_free_addr < w_dma_lim) begin
            w_free_zone = ZONE_DMA;
        end else if (w_free_addr < w_dma32_lim) begin
            w_free_zone = ZONE_DMA32;
        end else begin
            w_free_zone = ZONE_NORMAL;
        end
    end

    // Alloc: pick the first non-empty zone in the order the address bound allows.
    always_comb begin
        w_alloc_zone = ZONE_NORMAL;
        w_found      = 1'b0;
        if (i_max_address <= w_dma_lim) begin
            w_alloc_zone = ZONE_DMA;
            w_found      = w_dma_ne;
        end else if (i_max_address <= w_dma32_lim) begin
            w_found = w_dma_ne || w_dma32_ne;
            if (w_dma_ne) begin
                w_alloc_zone = ZONE_DMA;
            end else begin
                w_alloc_zone = ZONE_DMA32;
            end
        end else begin
            w_found = w_norm_ne || w_dma32_ne || w_dma_ne;
            if (w_norm_ne) begin
                w_alloc_zone = ZONE_NORMAL;
            end else if (w_dma32_ne) begin
                w_alloc_zone = ZONE_DMA32;
            end else if (w_dma_ne) begin
                w_alloc_zone = ZONE_DMA;
            end
        end
    end

    assign w_zone = (i_opcode == OP_ALLOC) ? w_alloc_zone : w_free_zone;

    always_comb begin
        unique case (w_zone)
            ZONE_DMA:    w_top = r_top_dma;
            ZONE_DMA32:  w_top = r_top_dma32;
            ZONE_NORMAL: w_top = r_top_norm;
            default:     w_top = r_top_norm;
        endcase
    end

    assign w_full    = (w_top >= FULL_CNT);
    assign w_top_dec = w_top - TW'(1);
    assign w_push    = w_accept && (i_opcode == OP_FREE) && !w_page_null && !w_full;
    assign w_pop     = w_accept && (i_opcode == OP_ALLOC) && w_found;
    assign w_wr_addr = {w_zone, w_top[AW-1:0]};
    assign w_rd_addr = {w_zone, w_top_dec[AW-1:0]};
    assign n_top     = w_push ? (w_top + TW'(1)) : w_top_dec;

    always_comb begin
        n_total = r_total;
        if (w_push) begin
            n_total = r_total + TOTAL_W'(1);
        end else if (w_pop) begin
            n_total = r_total - TOTAL_W'(1);
        end
    end

    always_comb begin
        if (i_opcode == OP_ALLOC) begin
            n_status = w_found ? ST_OK : ST_NONE;
        end else if (w_page_null) begin
            n_status = ST_NULL;
        end else if (w_full) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_OK;
        end
    end

    // ------------------------------------------------------------------
    // Stack RAM: push writes at top, pop reads at top-1. Requests are serial
    // and a write lands at the edge that accepts it, so a pop right after a
    // push to the same zone already sees the new entry.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            mem[w_wr_addr] <= i_page_number;
        end
        if (w_pop) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run         <= 1'b0;
            r_dma_limit   <= DMA_LIMIT_RST;
            r_dma32_limit <= DMA32_LIMIT_RST;
            r_top_dma     <= '0;
            r_top_dma32   <= '0;
            r_top_norm    <= '0;
            r_total       <= '0;
            r_strobe      <= 1'b0;
            r_status      <= ST_OK;
            r_grant       <= 1'b0;
        end else begin
            r_run    <= 1'b1;
            r_strobe <= w_accept;
            if (w_accept) begin
                r_status <= n_status;
                r_grant  <= w_pop;
                r_total  <= n_total;
            end
            if (w_push || w_pop) begin
                unique case (w_zone)
                    ZONE_DMA:    r_top_dma   <= n_top;
                    ZONE_DMA32:  r_top_dma32 <= n_top;
                    ZONE_NORMAL: r_top_norm  <= n_top;
                    default:     r_top_norm  <= r_top_norm;
                endcase
            end
            // Limits keep only the low 52 bits of the write data.
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_DMA_LIMIT:   r_dma_limit   <= i_cfg_data[LIMIT_W-1:0];
                    CFG_DMA32_LIMIT: r_dma32_limit <= i_cfg_data[LIMIT_W-1:0];
                    default:         r_dma_limit   <= r_dma_limit;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign busy           = !r_run;
    assign o_cfg_ready    = r_run && !start;
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_granted_page = r_grant ? r_rd_data : '0;
    assign o_free_total   = r_total;

`ifndef ASSERT_OFF
    // One result per accepted request, in the cycle after it.
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1 |=> (o_strobe == $past(start && !busy)))
        else $error("result strobe does not match accepted request");

    // Free total tracks the sum of stack depths.
    a_total_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total == TOTAL_W'(32'(r_top_dma) + 32'(r_top_dma32) + 32'(r_top_norm)))
        else $error("free total out of step with stack pointers");

    // No stack pointer runs past its depth.
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_top_dma <= FULL_CNT) && (r_top_dma32 <= FULL_CNT) && (r_top_norm <= FULL_CNT))
        else $error("stack pointer beyond zone depth");

    // A granted page is never null, and only a successful alloc grants.
    a_grant_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_grant) |-> ((o_granted_page != '0) && (o_status == ST_OK)))
        else $error("granted page null or status wrong");
`endif

endmodule

/* bench/testbench.sv */
// Self-checking bench for the zoned free page allocator: random and directed frees and allocs.
`timescale 1ns / 1ps

module testbench;
    import zfpa_pkg::*;

    localparam int PAGE_W = PAGE_BITS_DEF;
    localparam int DEPTH  = ZONE_DEPTH_DEF;

    // One expected reply of the allocator.
    typedef struct packed {
        t_status              status;
        logic [PAGE_W-1:0]    page;
        logic [TOTAL_W-1:0]   total;
    } t_outcome;

    // ------------------------------------------------------------------
    // Page ledger: our own copy of the three zone stacks and the limits.
    // Every accepted request is played into it, and what the block ought
    // to answer is queued; every strobed reply is matched to the oldest.
    // ------------------------------------------------------------------
    class zone_ledger;
        logic [LIMIT_W-1:0] dma_limit;
        logic [LIMIT_W-1:0] dma32_limit;
        logic [PAGE_W-1:0]  pages [3][DEPTH];
        int                 fill [3];
        int                 total;
        t_outcome           awaited [$];
        int                 errors;
        int                 frees;
        int                 allocs;
        int                 limit_writes;
        int                 full_rejects;
        int                 status_seen [4];

        function new();
            dma_limit   = DMA_LIMIT_RST;
            dma32_limit = DMA32_LIMIT_RST;
            total       = 0;
            foreach (fill[z]) fill[z] = 0;
            foreach (status_seen[s]) status_seen[s] = 0;
            errors = 0;
            frees = 0;
            allocs = 0;
            limit_writes = 0;
            full_rejects = 0;
        endfunction

        // Only the low 52 bits of the write data land in a limit.
        function void write_limit(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            limit_writes++;
            if (idx == CFG_DMA_LIMIT)
                dma_limit = data[LIMIT_W-1:0];
            else
                dma32_limit = data[LIMIT_W-1:0];
        endfunction

        // Zero means the stack was empty; a null page is never stacked.
        function logic [PAGE_W-1:0] take_page(t_zone z);
            if (fill[z] == 0)
                return '0;
            fill[z]--;
            total--;
            return pages[z][fill[z]];
        endfunction

        function void note_request(logic op, logic [PAGE_W-1:0] pg, logic [MAXA_W-1:0] reach);
            t_outcome           o;
            logic [LIMIT_W-1:0] addr;
            t_zone              z;
            o.status = ST_OK;
            o.page   = '0;
            if (op == OP_FREE) begin
                frees++;
                if (pg == '0) begin
                    o.status = ST_NULL;
                end else begin
                    addr = LIMIT_W'(pg) << PAGE_SHIFT;
                    // DMA is tested first, so out-of-order limits favor DMA
                    if (addr < dma_limit)
                        z = ZONE_DMA;
                    else if (addr < dma32_limit)
                        z = ZONE_DMA32;
                    else
                        z = ZONE_NORMAL;
                    if (fill[z] >= DEPTH) begin
                        o.status = ST_FULL;
                        full_rejects++;
                    end else begin
                        pages[z][fill[z]] = pg;
                        fill[z]++;
                        total++;
                    end
                end
            end else begin
                allocs++;
                if (reach <= MAXA_W'(dma_limit)) begin
                    o.page = take_page(ZONE_DMA);
                end else if (reach <= MAXA_W'(dma32_limit)) begin
                    o.page = take_page(ZONE_DMA);
                    if (o.page == '0) o.page = take_page(ZONE_DMA32);
                end else begin
                    o.page = take_page(ZONE_NORMAL);
                    if (o.page == '0) o.page = take_page(ZONE_DMA32);
                    if (o.page == '0) o.page = take_page(ZONE_DMA);
                end
                if (o.page == '0) o.status = ST_NONE;
            end
            o.total = TOTAL_W'(total);
            awaited.push_back(o);
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
        endfunction

        function void check_result(t_status st, logic [PAGE_W-1:0] pg,
                                   logic [TOTAL_W-1:0] tot);
            t_outcome o;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: reply with no request outstanding: status %0d page %h total %0d",
                         $time, st, pg, tot);
                return;
            end
            o = awaited.pop_front();
            status_seen[o.status]++;
            if (st !== o.status) flag("status", 64'(o.status), 64'(st));
            if (pg !== o.page) flag("granted page", 64'(o.page), 64'(pg));
            if (tot !== o.total) flag("free total", 64'(o.total), 64'(tot));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_opcode;
    logic [PAGE_W-1:0]     i_page_number;
    logic [MAXA_W-1:0]     i_max_address;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_strobe;
    t_status               o_status;
    logic [PAGE_W-1:0]     o_granted_page;
    logic [TOTAL_W-1:0]    o_free_total;

    zone_ledger ledger;
    int         idle_pct;   // chance, in percent, that the sender rests after a request

    zoned_free_page_allocator_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_page_number  (i_page_number),
        .i_max_address  (i_max_address),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_granted_page (o_granted_page),
        .o_free_total   (o_free_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Replies are strobed for one cycle and cannot be held off, so each
    // strobe seen at an edge is checked right there.
    always @(posedge i_clk) begin
        if (o_strobe === 1'b1)
            ledger.check_result(o_status, o_granted_page, o_free_total);
    end

    // Present one request and hold it until the block takes it (start high,
    // busy low at an edge). Start stays high when the next request follows
    // at once; otherwise the sender drops start and rests before the next request.
    task automatic issue(input logic op, input logic [PAGE_W-1:0] pg,
                         input logic [MAXA_W-1:0] reach);
        start         <= 1'b1;
        i_opcode      <= op;
        i_page_number <= pg;
        i_max_address <= reach;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        ledger.note_request(op, pg, reach);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Sender pauses until every reply is in; the block is then idle.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (ledger.awaited.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_limit(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        ledger.write_limit(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Page numbers: log-spread over the whole range so every zone is hit,
    // plus null pages and pages right at either zone boundary.
    function automatic logic [PAGE_W-1:0] pick_page();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       return '0;
            1, 2:    return r[PAGE_W-1:0];
            3:       return PAGE_W'(ledger.dma_limit >> PAGE_SHIFT)
                            + PAGE_W'($urandom_range(2)) - PAGE_W'(1);
            4:       return PAGE_W'(ledger.dma32_limit >> PAGE_SHIFT)
                            + PAGE_W'($urandom_range(2)) - PAGE_W'(1);
            default: return r[PAGE_W-1:0] >> $urandom_range(PAGE_W - 1);
        endcase
    endfunction

    // Highest acceptable address: any-zone, zero, at and around each limit,
    // and log-spread values.
    function automatic logic [MAXA_W-1:0] pick_reach();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       return '1;
            1:       return r;
            2:       return MAXA_W'(ledger.dma_limit) + MAXA_W'($urandom_range(2)) - MAXA_W'(1);
            3:       return MAXA_W'(ledger.dma32_limit) + MAXA_W'($urandom_range(2))
                            - MAXA_W'(1);
            4:       return '0;
            default: return r >> $urandom_range(MAXA_W - 1);
        endcase
    endfunction

    // Both fields always carry random content; the block ignores the one
    // that does not apply to the opcode.
    task automatic random_request(input int free_pct);
        logic op;
        op = ($urandom_range(99) < free_pct) ? OP_FREE : OP_ALLOC;
        issue(op, pick_page(), pick_reach());
    endtask

    task automatic mixed_phase(input int count, input int free_pct);
        for (int k = 0; k < count; k++)
            random_request(free_pct);
    endtask

    initial begin
        logic [63:0] lim_a;
        logic [63:0] lim_b;
        int          n;

        ledger = new();
        idle_pct = 0;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_opcode      <= OP_FREE;
        i_page_number <= '0;
        i_max_address <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_DMA_LIMIT;
        i_cfg_data    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed: default limits, DMA below 16 MiB, DMA32 below 4 GiB ----
        issue(OP_ALLOC, '0, '1);                    // nothing free yet
        issue(OP_FREE, '0, '1);                     // null page is ignored
        issue(OP_FREE, 40'h1, '0);                  // lowest DMA page
        issue(OP_FREE, 40'hFFF, '0);                // last page under the DMA limit
        issue(OP_FREE, 40'h1000, '0);               // exactly at the DMA limit: DMA32
        issue(OP_FREE, 40'hF_FFFF, '0);             // last DMA32 page
        issue(OP_FREE, 40'h10_0000, '0);            // exactly at the DMA32 limit: normal
        issue(OP_FREE, '1, '1);                     // highest page number
        issue(OP_ALLOC, '1, '0);                    // DMA only, newest first
        issue(OP_ALLOC, '0, MAXA_W'(DMA_LIMIT_RST));
        issue(OP_ALLOC, '0, MAXA_W'(DMA_LIMIT_RST)); // DMA empty, DMA32 not allowed
        issue(OP_ALLOC, '0, MAXA_W'(DMA_LIMIT_RST) + 64'd1);
        issue(OP_ALLOC, '0, MAXA_W'(DMA32_LIMIT_RST));
        issue(OP_ALLOC, '0, MAXA_W'(DMA32_LIMIT_RST)); // normal not allowed
        issue(OP_ALLOC, '0, MAXA_W'(DMA32_LIMIT_RST) + 64'd1);
        issue(OP_FREE, 40'h5, '1);
        issue(OP_FREE, 40'h2000, '1);
        issue(OP_FREE, 40'h10_0001, '0);
        issue(OP_ALLOC, '0, '1);                    // any zone: normal first
        issue(OP_ALLOC, '0, '1);                    // normal again
        issue(OP_ALLOC, '0, '1);                    // then DMA32
        issue(OP_ALLOC, '0, '1);                    // then DMA, leaving all empty
        issue(OP_FREE, 40'h7, '0);
        issue(OP_FREE, 40'h7, '0);                  // double free goes unnoticed
        issue(OP_ALLOC, '0, '0);
        issue(OP_ALLOC, '0, '0);

        // ---- random, default limits, back to back ----
        mixed_phase(20, 55);

        // ---- DMA zone empty, everything else DMA32; sender mostly idle ----
        settle();
        write_limit(CFG_DMA_LIMIT, '0);
        write_limit(CFG_DMA32_LIMIT, '1);           // upper data bits are dropped
        idle_pct = 65;
        mixed_phase(20, 55);

        // ---- limits out of order: every page lands in DMA ----
        settle();
        write_limit(CFG_DMA_LIMIT, '1);
        write_limit(CFG_DMA32_LIMIT, '0);
        idle_pct = 13;
        mixed_phase(20, 55);

        // ---- random ordered limits, junk in the unused data bits ----
        settle();
        lim_a = {$urandom, $urandom} >> $urandom_range(20, 40);
        lim_b = lim_a + ({$urandom, $urandom} >> $urandom_range(16, 40));
        write_limit(CFG_DMA_LIMIT, {12'($urandom), lim_a[LIMIT_W-1:0]});
        write_limit(CFG_DMA32_LIMIT, {12'($urandom), lim_b[LIMIT_W-1:0]});
        idle_pct = 65;
        mixed_phase(20, 55);

        // ---- defaults again; pile pages into DMA until it overflows a while ----
        settle();
        write_limit(CFG_DMA_LIMIT, MAXA_W'(DMA_LIMIT_RST));
        write_limit(CFG_DMA32_LIMIT, MAXA_W'(DMA32_LIMIT_RST));
        n = 0;
        while (ledger.full_rejects < 20) begin
            case ((n / 150) % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 65;
                default: idle_pct = 13;
            endcase
            if ($urandom_range(99) < 94)
                issue(OP_FREE, PAGE_W'($urandom_range(1, 'hFFF)), {$urandom, $urandom});
            else
                random_request(50);
            n++;
        end

        // ---- everything freed goes normal; mostly allocs unwind the DMA pile ----
        settle();
        write_limit(CFG_DMA_LIMIT, '0);
        write_limit(CFG_DMA32_LIMIT, '0);
        idle_pct = 13;
        mixed_phase(40, 30);

        start <= 1'b0;
        @(posedge i_clk);
        while (ledger.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Ran %0d requests (%0d frees, %0d allocs) with %0d limit writes over six layouts.",
                 ledger.frees + ledger.allocs, ledger.frees, ledger.allocs, ledger.limit_writes);
        $display("Replies: %0d granted or stacked, %0d no page, %0d zone full, %0d null ignored.",
                 ledger.status_seen[ST_OK], ledger.status_seen[ST_NONE],
                 ledger.status_seen[ST_FULL], ledger.status_seen[ST_NULL]);
        if (ledger.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: a run that has not finished by this delay is reported as a failure.
    initial begin
        #(2_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
rtl/zfpa_pkg.sv
rtl/zoned_free_page_allocator_top.sv
bench/testbench.sv
